// File: rtl/core/ihq_pkg.sv
// Shared types and constants for the indexed min-heap queue.
// Used by every module under rtl/core except ihq_ram, and by the testbench; depends on nothing.
package ihq_pkg;

    localparam int ITEM_BITS  = 10;
    localparam int COST_FIELD = 32;
    localparam int COUNT_FIELD = 11;
    localparam int STATUS_BITS = 3;
    localparam int ITEM_SPACE = 1 << ITEM_BITS;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_POP = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_QUEUED     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOT_QUEUED = 3'd4;

    typedef struct packed {
        logic [1:0]            mode;
        logic [ITEM_BITS-1:0]  item;
        logic [COST_FIELD-1:0] cost;
    } req_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0]   removed_item;
        logic [COST_FIELD-1:0]  removed_cost;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_FIELD-1:0] count;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR_STEP,
        OP_LOAD,
        OP_FAIL,
        OP_ADD,
        OP_DEC,
        OP_POP_RD0,
        OP_POP_LAST,
        OP_POP_MOVED,
        OP_POP_RCOST,
        OP_POP_MCOST,
        OP_UP_READ,
        OP_UP_PCOST,
        OP_UP_MOVE,
        OP_PLACE,
        OP_DN_READ,
        OP_DN_LEFT,
        OP_DN_RIGHT,
        OP_DN_PICK,
        OP_DN_MOVE,
        OP_CLR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [STATUS_BITS-1:0] st;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       pos_valid;
        logic       full;
        logic       empty;
        logic       slot_zero;
        logic       parent_le;
        logic       child_oob;
        logic       has_right;
        logic       moved_lt;
        logic       clr_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// File: rtl/core/ihq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for every store of the heap queue.
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/ihq_datapath.sv
// Datapath of the heap queue: heap, position and cost memories, work registers.
// Depends on ihq_pkg and ihq_ram; steered by ihq_ctrl through dp_cmd_t.
module ihq_datapath #(
    parameter int MAX_ITEMS = 1024,
    parameter int COST_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ihq_pkg::dp_cmd_t  cmd,
    output ihq_pkg::dp_stat_t stat,
    input  ihq_pkg::req_t     req,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output ihq_pkg::rsp_t     rsp
);
    import ihq_pkg::*;

    localparam int SW  = $clog2(MAX_ITEMS);
    localparam int CNW = $clog2(MAX_ITEMS + 1);
    localparam int CHW = SW + 2;
    localparam int PW  = SW + 1;
    localparam int CW  = (COST_BITS < COST_FIELD) ? COST_BITS : COST_FIELD;

    logic [1:0]           mode_reg;
    logic [ITEM_BITS-1:0] item_reg, citem_reg, ritem_reg, root_reg, res_item_reg, clr_reg;
    logic [CW-1:0]        cost_reg, ccost_reg, res_cost_reg;
    logic [CNW-1:0]       count_reg;
    logic [SW-1:0]        slot_reg, parent_reg;
    logic [CHW-1:0]       child_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic                 heap_we, heap_re;
    logic [SW-1:0]        heap_wa, heap_ra;
    logic [ITEM_BITS-1:0] heap_wd, heap_rd;
    logic                 pos_we, pos_re;
    logic [ITEM_BITS-1:0] pos_wa, pos_ra;
    logic [PW-1:0]        pos_wd, pos_rd;
    logic                 cost_we, cost_re;
    logic [ITEM_BITS-1:0] cost_wa, cost_ra;
    logic [CW-1:0]        cost_wd, cost_rd;

    logic [CHW-1:0] child_calc, rchild_calc;
    logic [SW-1:0]  parent_calc, dec_slot, last_slot;
    logic           right_lt, out_free;

    ihq_ram #(.WIDTH(ITEM_BITS), .DEPTH(MAX_ITEMS)) u_heap (
        .clk(clk), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
        .rd_en(heap_re), .rd_addr(heap_ra), .rd_data(heap_rd)
    );

    ihq_ram #(.WIDTH(PW), .DEPTH(ITEM_SPACE)) u_pos (
        .clk(clk), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
        .rd_en(pos_re), .rd_addr(pos_ra), .rd_data(pos_rd)
    );

    ihq_ram #(.WIDTH(CW), .DEPTH(ITEM_SPACE)) u_cost (
        .clk(clk), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(cost_wd),
        .rd_en(cost_re), .rd_addr(cost_ra), .rd_data(cost_rd)
    );

    assign child_calc  = CHW'({slot_reg, 1'b1});
    assign rchild_calc = child_reg + CHW'(1);
    assign parent_calc = SW'((slot_reg - SW'(1)) >> 1);
    assign last_slot   = SW'(count_reg - CNW'(1));
    // A stale position beyond the fill level falls back to the root.
    assign dec_slot    = (CNW'(pos_rd[SW-1:0]) < count_reg) ? pos_rd[SW-1:0] : '0;
    assign right_lt    = cost_rd < ccost_reg;
    assign out_free    = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.pos_valid = pos_rd[SW];
        stat.full      = count_reg >= CNW'(MAX_ITEMS);
        stat.empty     = count_reg == '0;
        stat.slot_zero = slot_reg == '0;
        stat.parent_le = cost_rd <= cost_reg;
        stat.child_oob = child_calc >= CHW'(count_reg);
        stat.has_right = rchild_calc < CHW'(count_reg);
        stat.moved_lt  = cost_reg < ccost_reg;
        stat.clr_last  = clr_reg == ITEM_BITS'(ITEM_SPACE - 1);
        stat.out_free  = out_free;
    end

    always_comb
    begin
        heap_we = 1'b0;
        heap_wa = slot_reg;
        heap_wd = item_reg;
        heap_re = 1'b0;
        heap_ra = '0;
        pos_we  = 1'b0;
        pos_wa  = item_reg;
        pos_wd  = {1'b1, slot_reg};
        pos_re  = 1'b0;
        pos_ra  = req.item;
        cost_we = 1'b0;
        cost_wa = item_reg;
        cost_wd = cost_reg;
        cost_re = 1'b0;
        cost_ra = item_reg;
        case (cmd.op)
            OP_CLEAR_STEP:
            begin
                pos_we = 1'b1;
                pos_wa = clr_reg;
                pos_wd = '0;
            end
            OP_LOAD:
            begin
                pos_re = 1'b1;
            end
            OP_ADD, OP_DEC:
            begin
                cost_we = 1'b1;
            end
            OP_POP_RD0:
            begin
                heap_re = 1'b1;
            end
            OP_POP_LAST:
            begin
                heap_re = 1'b1;
                heap_ra = last_slot;
            end
            OP_POP_MOVED:
            begin
                cost_re = 1'b1;
                cost_ra = root_reg;
            end
            OP_POP_RCOST:
            begin
                cost_re = 1'b1;
                cost_ra = heap_rd;
            end
            OP_UP_READ:
            begin
                heap_re = 1'b1;
                heap_ra = parent_calc;
            end
            OP_UP_PCOST, OP_DN_RIGHT:
            begin
                cost_re = 1'b1;
                cost_ra = heap_rd;
            end
            OP_PLACE:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            OP_UP_MOVE, OP_DN_MOVE:
            begin
                heap_we = 1'b1;
                heap_wd = citem_reg;
                pos_we  = 1'b1;
                pos_wa  = citem_reg;
            end
            OP_DN_READ:
            begin
                heap_re = 1'b1;
                heap_ra = child_calc[SW-1:0];
            end
            OP_DN_LEFT:
            begin
                cost_re = 1'b1;
                cost_ra = heap_rd;
                heap_re = 1'b1;
                heap_ra = rchild_calc[SW-1:0];
            end
            OP_CLR:
            begin
                pos_we = 1'b1;
                pos_wa = root_reg;
                pos_wd = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_ADD)
            begin
                count_reg <= count_reg + CNW'(1);
            end
            else if (cmd.op == OP_POP_LAST)
            begin
                count_reg <= count_reg - CNW'(1);
            end
            if (cmd.op == OP_CLEAR_STEP)
            begin
                clr_reg <= clr_reg + ITEM_BITS'(1);
            end
            if (cmd.op == OP_EMIT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg     <= req.mode;
                item_reg     <= req.item;
                cost_reg     <= CW'(req.cost);
                status_reg   <= ST_OK;
                res_item_reg <= '0;
                res_cost_reg <= '0;
            end
            OP_FAIL:      status_reg <= cmd.st;
            OP_ADD:       slot_reg <= SW'(count_reg);
            OP_DEC:       slot_reg <= dec_slot;
            OP_POP_LAST:
            begin
                root_reg     <= heap_rd;
                res_item_reg <= heap_rd;
            end
            OP_POP_MOVED: item_reg <= heap_rd;
            OP_POP_RCOST: res_cost_reg <= cost_rd;
            OP_POP_MCOST:
            begin
                cost_reg <= cost_rd;
                slot_reg <= '0;
            end
            OP_UP_READ:   parent_reg <= parent_calc;
            OP_UP_PCOST:  citem_reg <= heap_rd;
            OP_UP_MOVE:   slot_reg <= parent_reg;
            OP_DN_READ:   child_reg <= child_calc;
            OP_DN_LEFT:   citem_reg <= heap_rd;
            OP_DN_RIGHT:
            begin
                ccost_reg <= cost_rd;
                ritem_reg <= heap_rd;
            end
            OP_DN_PICK:
            begin
                if (right_lt)
                begin
                    child_reg <= rchild_calc;
                    citem_reg <= ritem_reg;
                    ccost_reg <= cost_rd;
                end
            end
            OP_DN_MOVE:   slot_reg <= child_reg[SW-1:0];
            OP_EMIT:
            begin
                rsp_reg.removed_item <= res_item_reg;
                rsp_reg.removed_cost <= COST_FIELD'(res_cost_reg);
                rsp_reg.status       <= status_reg;
                rsp_reg.count        <= COUNT_FIELD'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(MAX_ITEMS))
        else $error("heap fill level beyond capacity");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_ADD |=> count_reg == $past(count_reg) + CNW'(1))
        else $error("add did not grow the heap by one");

    // Removing the last item still writes the root slot of the now empty heap.
    a_place_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PLACE || cmd.op == OP_UP_MOVE || cmd.op == OP_DN_MOVE)
        |-> (CNW'(slot_reg) < count_reg || count_reg == '0))
        else $error("heap write outside the filled slots");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> out_free)
        else $error("response register overwritten while still pending");

endmodule

// File: rtl/core/ihq_ctrl.sv
// Sequencer of the heap queue: request decode, sift-up and sift-down walks.
// Depends on ihq_pkg; drives ihq_datapath through dp_cmd_t.
module ihq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output ihq_pkg::dp_cmd_t  cmd,
    input  ihq_pkg::dp_stat_t stat
);
    import ihq_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK,
        S_POP_LAST, S_POP_MOVED, S_POP_RCOST, S_POP_MCOST,
        S_UP_A, S_UP_B, S_UP_C,
        S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_DN_E,
        S_CLR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        cmd.st     = ST_OK;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR_STEP;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                unique case (stat.mode)
                    MODE_ADD:
                    begin
                        if (stat.pos_valid)
                        begin
                            cmd.op = OP_FAIL;
                            cmd.st = ST_QUEUED;
                        end
                        else if (stat.full)
                        begin
                            cmd.op = OP_FAIL;
                            cmd.st = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_ADD;
                            state_next = S_UP_A;
                        end
                    end
                    MODE_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.op = OP_FAIL;
                            cmd.st = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = OP_POP_RD0;
                            state_next = S_POP_LAST;
                        end
                    end
                    MODE_DEC:
                    begin
                        if (!stat.pos_valid)
                        begin
                            cmd.op = OP_FAIL;
                            cmd.st = ST_NOT_QUEUED;
                        end
                        else
                        begin
                            cmd.op     = OP_DEC;
                            state_next = S_UP_A;
                        end
                    end
                    default:
                    begin
                        cmd.op = OP_IDLE;
                    end
                endcase
            end
            S_POP_LAST:
            begin
                cmd.op     = OP_POP_LAST;
                state_next = S_POP_MOVED;
            end
            S_POP_MOVED:
            begin
                cmd.op     = OP_POP_MOVED;
                state_next = S_POP_RCOST;
            end
            S_POP_RCOST:
            begin
                cmd.op     = OP_POP_RCOST;
                state_next = S_POP_MCOST;
            end
            S_POP_MCOST:
            begin
                cmd.op     = OP_POP_MCOST;
                state_next = S_DN_A;
            end
            S_UP_A:
            begin
                if (stat.slot_zero)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_UP_READ;
                    state_next = S_UP_B;
                end
            end
            S_UP_B:
            begin
                cmd.op     = OP_UP_PCOST;
                state_next = S_UP_C;
            end
            S_UP_C:
            begin
                // Equal parent cost stops the walk.
                if (stat.parent_le)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = S_UP_A;
                end
            end
            S_DN_A:
            begin
                if (stat.child_oob)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.op     = OP_DN_READ;
                    state_next = S_DN_B;
                end
            end
            S_DN_B:
            begin
                cmd.op     = OP_DN_LEFT;
                state_next = S_DN_C;
            end
            S_DN_C:
            begin
                cmd.op     = OP_DN_RIGHT;
                state_next = stat.has_right ? S_DN_D : S_DN_E;
            end
            S_DN_D:
            begin
                cmd.op     = OP_DN_PICK;
                state_next = S_DN_E;
            end
            S_DN_E:
            begin
                // The moved item keeps sinking on a tie with the child.
                if (stat.moved_lt)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.op     = OP_DN_MOVE;
                    state_next = S_DN_A;
                end
            end
            S_CLR:
            begin
                cmd.op     = OP_CLR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/indexed_min_heap_queue.sv
// Top level of the indexed binary min-heap queue with decrease-key.
// Depends on ihq_pkg, ihq_ctrl and ihq_datapath (which holds the ihq_ram stores).
//
//   channel | handshake             | word
//   --------+-----------------------+-----------------------------------------
//   request | req_valid / req_ready | req: mode, item, cost
//   result  | rsp_valid / rsp_ready | rsp: removed_item, removed_cost, status, count
//
// One request at a time. Add and decrease climb one level per pass through S_UP_A, S_UP_B
// and S_UP_C; remove sinks through S_DN_A to S_DN_E per level, about log2(MAX_ITEMS) levels.
// The single read port of each store splits each level into these separate steps.
// After reset a clearing pass over all ITEM_SPACE entries empties the position store; no
// request is taken meanwhile. The result register lets the next request start
// while a word waits; a stalled result only holds the following one at its end.
module indexed_min_heap_queue #(
    parameter int MAX_ITEMS = 1024,
    parameter int COST_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ihq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ihq_pkg::rsp_t rsp
);
    import ihq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ihq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .cmd(cmd), .stat(stat)
    );

    ihq_datapath #(.MAX_ITEMS(MAX_ITEMS), .COST_BITS(COST_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .stat(stat),
        .req(req),
        .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp(rsp)
    );

endmodule

// File: tb/heap_queue_checker.sv
// Checker for the indexed min-heap queue: watches both channels, predicts each result word.
// Depends on ihq_pkg; instantiated by tb beside the block.
module heap_queue_checker
    import ihq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_ready,
    input  req_t  req,
    input  logic  rsp_valid,
    input  logic  rsp_ready,
    input  rsp_t  rsp,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 1024;

    logic [ITEM_BITS-1:0]   slot_item [HEAP_DEPTH];
    logic [10:0]            item_slot [ITEM_SPACE];
    logic                   item_queued [ITEM_SPACE];
    logic [COST_FIELD-1:0]  item_key [ITEM_SPACE];
    int unsigned            heap_size;
    rsp_t                   due_words[$];

    assign pending = due_words.size();

    function automatic void put_slot(int unsigned slot, logic [ITEM_BITS-1:0] it);
        slot_item[slot] = it;
        item_slot[it] = 11'(slot);
    endfunction

    function automatic void climb(int unsigned slot, logic [ITEM_BITS-1:0] it,
                                  logic [COST_FIELD-1:0] key);
        int unsigned parent;
        while (slot != 0)
        begin
            parent = (slot - 1) / 2;
            if (item_key[slot_item[parent]] <= key)
                break;
            put_slot(slot, slot_item[parent]);
            slot = parent;
        end
        put_slot(slot, it);
    endfunction

    function automatic logic [ITEM_BITS-1:0] take_top();
        logic [ITEM_BITS-1:0]  top;
        logic [ITEM_BITS-1:0]  moved;
        logic [ITEM_BITS-1:0]  citem;
        logic [COST_FIELD-1:0] mkey;
        logic [COST_FIELD-1:0] ckey;
        int unsigned           slot;
        int unsigned           child;
        top = slot_item[0];
        heap_size--;
        moved = slot_item[heap_size];
        mkey = item_key[moved];
        slot = 0;
        while (2 * slot + 1 < heap_size)
        begin
            child = 2 * slot + 1;
            citem = slot_item[child];
            ckey = item_key[citem];
            // The right child wins only when strictly cheaper.
            if (child + 1 < heap_size && item_key[slot_item[child + 1]] < ckey)
            begin
                child++;
                citem = slot_item[child];
                ckey = item_key[citem];
            end
            if (mkey < ckey)
                break;
            put_slot(slot, citem);
            slot = child;
        end
        put_slot(slot, moved);
        item_queued[top] = 1'b0;
        return top;
    endfunction

    function automatic rsp_t predict_word(req_t r);
        rsp_t w;
        int unsigned slot;
        w = '0;
        w.status = ST_OK;
        case (r.mode)
            MODE_ADD:
            begin
                if (item_queued[r.item])
                    w.status = ST_QUEUED;
                else if (heap_size >= HEAP_DEPTH)
                    w.status = ST_FULL;
                else
                begin
                    item_key[r.item] = r.cost;
                    item_queued[r.item] = 1'b1;
                    heap_size++;
                    climb(heap_size - 1, r.item, r.cost);
                end
            end
            MODE_POP:
            begin
                if (heap_size == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    w.removed_item = take_top();
                    w.removed_cost = item_key[w.removed_item];
                end
            end
            MODE_DEC:
            begin
                if (!item_queued[r.item])
                    w.status = ST_NOT_QUEUED;
                else
                begin
                    slot = item_slot[r.item];
                    if (slot >= heap_size)
                        slot = 0;
                    item_key[r.item] = r.cost;
                    climb(slot, r.item, r.cost);
                end
            end
            default:
            begin
            end
        endcase
        w.count = COUNT_FIELD'(heap_size);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ITEM_SPACE; i++)
                item_queued[i] = 1'b0;
            heap_size = 0;
            fail_count = 0;
            due_words.delete();
        end
        else
        begin
            if (req_valid && req_ready)
                due_words.push_back(predict_word(req));
            if (rsp_valid && rsp_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with nothing expected: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (rsp.removed_item !== want.removed_item)
                    begin
                        $error("removed_item: expected %0d, got %0d",
                               want.removed_item, rsp.removed_item);
                        fail_count++;
                    end
                    if (rsp.removed_cost !== want.removed_cost)
                    begin
                        $error("removed_cost: expected %h, got %h",
                               want.removed_cost, rsp.removed_cost);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp.count);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
// Top of the heap queue testbench: clock, reset, request stimulus, result stalls, verdict.
// Depends on ihq_pkg, the block indexed_min_heap_queue and heap_queue_checker.
module tb;
    import ihq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   hold_off;
    logic [ITEM_BITS-1:0] live_items[$];

    indexed_min_heap_queue uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    heap_queue_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sends one word, after a random gap unless no_gap is set, and holds it until accepted.
    // Valid stays up after acceptance; the next call or the caller drops it.
    task automatic send(logic [1:0] m, logic [ITEM_BITS-1:0] it, logic [31:0] c,
                        bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{mode: m, item: it, cost: c};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_cost();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ITEM_BITS-1:0] rand_live();
        if (live_items.size() == 0)
            return ITEM_BITS'($urandom);
        return live_items[$urandom_range(0, live_items.size() - 1)];
    endfunction

    // Result side: random stalls, plus one long hold-off when asked.
    initial
    begin
        int wait_n;
        bit held;
        rsp_ready = 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !held)
            begin
                rsp_ready <= 1'b0;
                repeat (300)
                    @(negedge clk);
                held = 1;
            end
            wait_n = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                wait_n = 0;
            if (wait_n != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (wait_n - 1)
                    @(negedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [ITEM_BITS-1:0] it;
        int                   pick;
        hold_off = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty remove, field extremes, duplicates, missing items, ties.
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_DEC, 10'd1023, 32'h0);
        send(MODE_ADD, 10'd1023, 32'hFFFF_FFFF);
        send(MODE_ADD, 10'd0, 32'h0);
        send(MODE_ADD, 10'd0, 32'h5);
        send(MODE_ADD, 10'd341, 32'h0);
        send(MODE_ADD, 10'd682, 32'h0001_0000);
        send(MODE_ADD, 10'd5, 32'h0001_0000);
        send(MODE_DEC, 10'd1023, 32'h0);
        send(MODE_DEC, 10'd682, 32'hFFFF_0000);
        send(MODE_DEC, 10'd5, 32'h0001_0000);
        send(2'd3, 10'h2AA, 32'hAAAA_5555);
        send(MODE_POP, 10'h3FF, 32'hFFFF_FFFF);
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_POP, 10'd0, 32'h0);
        send(MODE_DEC, 10'd0, 32'h0);

        // Back-to-back adds with the result side held off, so the input stalls.
        hold_off = 1;
        for (int i = 0; i < 30; i++)
            send(MODE_ADD, ITEM_BITS'($urandom), rand_cost(), 1);

        // Random: mostly valid adds, decreases and removes on live items.
        for (int n = 0; n < 430; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                it = ITEM_BITS'($urandom);
                send(MODE_ADD, it, rand_cost());
                if (!(it inside {live_items}))
                    live_items.push_back(it);
            end
            else if (pick < 65)
                send(MODE_DEC, rand_live(), rand_cost());
            else if (pick < 95)
            begin
                send(MODE_POP, ITEM_BITS'($urandom), $urandom);
                // Live list is approximate; only used to bias item choice.
                if (live_items.size() != 0)
                    live_items.delete($urandom_range(0, live_items.size() - 1));
            end
            else
                send(MODE_DEC, ITEM_BITS'($urandom), $urandom);
        end
        for (int n = 0; n < 20; n++)
            send(2'd3, ITEM_BITS'($urandom), $urandom);
        req_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/ihq_pkg.sv
rtl/core/ihq_ram.sv
rtl/core/ihq_datapath.sv
rtl/core/ihq_ctrl.sv
rtl/core/indexed_min_heap_queue.sv
tb/heap_queue_checker.sv
tb/tb.sv
